// ===== rtl/mexp_pkg.sv =====
// Package for the modular exponentiation unit: field widths, the prime,
// the Barrett constant, sequencer states and operation codes.
// No dependencies.
package mexp_pkg;

	localparam int FIELD_W  = 63;
	localparam int EXP_BITS = 63;
	localparam int RES_W    = 30;
	localparam int MUL_W    = RES_W + 1;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int DIFF_W   = RES_W + 2;

	localparam int S_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

	localparam int RED_BITS  = 3;
	localparam int RED_STEPS = (FIELD_W + RED_BITS - 1) / RED_BITS;
	localparam int RED_CNT_W = $clog2(RED_STEPS);
	localparam int RED_PAD_W = RED_STEPS * RED_BITS;

	localparam logic [RES_W-1:0] PRIME = RES_W'(998244353);
	// floor(2^(2*RES_W) / PRIME), fits in MUL_W bits
	localparam logic [MUL_W-1:0] MU =
		MUL_W'((64'd1 << (2 * RES_W)) / 64'(PRIME));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_CHK,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FIX,
		ST_FIN
	} mexp_state_t;

	typedef enum logic {
		OP_MUL,
		OP_SQR
	} mexp_op_t;

endpackage

// ===== rtl/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: base^exponent mod 998244353 by square and multiply.
// One shared 31x31 multiplier does the product and both Barrett steps.
// Depends on mexp_pkg.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: base[62:0], exponent[125:63]
// m_*      out  m_tvalid/m_tready  m_tdata: residue[29:0]
//
// Base reduction: 3 bits a cycle through one compare-subtract chain.
// Each modular product uses the multiplier for the product, the quotient
// estimate and quotient times prime, then a correction step. Per exponent bit
// up to the highest set one: a check state, a multiply if the bit is set, and
// a square (skipped after the top bit). The unit returns to idle after the
// result is loaded, before the next accept.
// s_tready is high only when idle; a finished word waits in the output
// register while the next word is taken. Async reset clears control only.
module modular_exponentiation_unit
	import mexp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // base[62:0], exponent[125:63]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // residue[29:0]
);

	mexp_state_t state_q, state_d;
	mexp_op_t    op_q;

	logic [RED_PAD_W-1:0] base_q;
	logic [RED_CNT_W-1:0] red_cnt_q;
	logic [EXP_BITS-1:0]  e_q;
	logic [RES_W-1:0]     acc_q;
	logic [RES_W-1:0]     sq_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DIFF_W-1:0]    x_lo_q;
	logic [RES_W-1:0]     residue_q;
	logic                 m_tvalid_q;

	logic [MUL_W-1:0]  opa, opb;
	logic [PROD_W-1:0] prod;
	logic [RES_W:0]    red_r, red_t;
	logic [DIFF_W-1:0] r_raw, r_one, r_two;
	logic              out_free;
	logic              more_bits;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(residue_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign more_bits = ((e_q >> 1) != '0);

	// shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			ST_MUL1: begin
				opa = (op_q == OP_MUL) ? {1'b0, acc_q} : {1'b0, sq_q};
				opb = {1'b0, sq_q};
			end
			ST_MUL2: begin
				opa = prod_q[RES_W-1 +: MUL_W];
				opb = MU;
			end
			ST_MUL3: begin
				opa = prod_q[RES_W+1 +: MUL_W];
				opb = {1'b0, PRIME};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		prod = opa * opb;
	end

	// Barrett correction: raw remainder below 3 * prime
	always_comb begin
		r_raw = x_lo_q - prod_q[DIFF_W-1:0];
		r_one = (r_raw >= DIFF_W'(PRIME)) ? r_raw - DIFF_W'(PRIME) : r_raw;
		r_two = (r_one >= DIFF_W'(PRIME)) ? r_one - DIFF_W'(PRIME) : r_one;
	end

	// base reduction, RED_BITS bits a cycle, msb first
	always_comb begin
		red_r = {1'b0, sq_q};
		red_t = '0;
		for (int k = 0; k < RED_BITS; k++) begin
			red_t = {red_r[RES_W-1:0], base_q[RED_PAD_W-1-k]};
			red_r = (red_t >= {1'b0, PRIME}) ? red_t - {1'b0, PRIME} : red_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_d = ST_RED;
			end
			ST_RED: begin
				if (red_cnt_q == RED_CNT_W'(RED_STEPS - 1))
					state_d = ST_CHK;
			end
			ST_CHK:  state_d = (e_q == '0) ? ST_FIN : ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_FIX;
			ST_FIX: begin
				if (op_q == OP_MUL)
					state_d = more_bits ? ST_MUL1 : ST_FIN;
				else
					state_d = ST_CHK;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				base_q    <= RED_PAD_W'(s_tdata[FIELD_W-1:0]);
				e_q       <= s_tdata[FIELD_W +: EXP_BITS];
				acc_q     <= RES_W'(1);
				sq_q      <= '0;
				red_cnt_q <= '0;
			end
			ST_RED: begin
				sq_q      <= red_r[RES_W-1:0];
				base_q    <= base_q << RED_BITS;
				red_cnt_q <= red_cnt_q + 1'b1;
			end
			ST_CHK: begin
				op_q <= e_q[0] ? OP_MUL : OP_SQR;
			end
			ST_MUL1: begin
				prod_q <= prod;
				x_lo_q <= prod[DIFF_W-1:0];
			end
			ST_MUL2, ST_MUL3: begin
				prod_q <= prod;
			end
			ST_FIX: begin
				if (op_q == OP_MUL) begin
					acc_q <= r_two[RES_W-1:0];
					op_q  <= OP_SQR;
				end else begin
					sq_q <= r_two[RES_W-1:0];
					e_q  <= e_q >> 1;
				end
			end
			ST_FIN: begin
				if (out_free)
					residue_q <= acc_q;
			end
			default: ;
		endcase
	end

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (acc_q < PRIME && sq_q < PRIME))
		else $error("running residue out of range");

	a_barrett_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> (r_raw < 3 * DIFF_W'(PRIME)))
		else $error("Barrett remainder above bound");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_RED))
		else $error("accepted word did not start reduction");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FIN))
		else $error("output word loaded outside finish state");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (residue_q < PRIME))
		else $error("residue out of range");

endmodule
